// ----- rtl/convex_hull_gift_wrap_macros.svh -----
// assertion macros for the convex hull gift wrap block
`ifndef CONVEX_HULL_GIFT_WRAP_MACROS_SVH
`define CONVEX_HULL_GIFT_WRAP_MACROS_SVH

// consequent holds in the same cycle
`define CHGW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the next cycle
`define CHGW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/chgw_pkg.sv -----
// shared constants and types of the convex hull gift wrap block
`default_nettype none

package chgw_pkg;

  localparam int unsigned MaxPoints = 64;
  localparam int unsigned CoordBits = 16;
  localparam int unsigned IdxW      = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned CntW      = $clog2(MaxPoints + 1);
  localparam int unsigned DataW     = ((2 * CoordBits + 7) / 8) * 8;
  localparam int unsigned DiffW     = CoordBits + 1;
  localparam int unsigned ProdW     = 2 * DiffW;
  localparam int unsigned CrossW    = ProdW + 1;

  typedef logic [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t y;
    coord_t x;
  } point_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_VTX,
    ST_CAND,
    ST_RD,
    ST_MUL,
    ST_CMP,
    ST_ADV,
    ST_OUT_RD,
    ST_OUT_CAP,
    ST_OUT_WAIT
  } state_e;

  typedef struct packed {
    logic load;
    logic last_in;
    logic vtx;
    logic cand;
    logic rd;
    logic mul;
    logic cmp;
    logic adv;
    logic out_rd;
    logic out_cap;
    logic out_done;
  } cmd_t;

  typedef struct packed {
    logic last_i;
    logic at_start;
    logic cap_hit;
    logic last_out;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/chgw_dp.sv -----
// datapath: point store, vertex buffer, cross product unit and output register
`default_nettype none

module chgw_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  chgw_pkg::cmd_t    cmd_i,
  input  chgw_pkg::point_t  pt_i,
  output chgw_pkg::stat_t   stat_o,
  output chgw_pkg::point_t  out_pt_o,
  output logic              out_last_o,
  output logic              out_ovf_o
);

  chgw_pkg::point_t store_mem [chgw_pkg::MaxPoints];
  chgw_pkg::point_t walk_mem  [chgw_pkg::MaxPoints];
  chgw_pkg::point_t store_rd_q;
  chgw_pkg::point_t walk_rd_q;

  logic [chgw_pkg::CntW-1:0] count_q;
  logic [chgw_pkg::CntW-1:0] emit_q;
  logic                      dropped_q;
  logic                      capped_q;
  logic [chgw_pkg::IdxW-1:0] k_q;
  logic [chgw_pkg::IdxW-1:0] i_q;
  logic [chgw_pkg::IdxW-1:0] cur_idx_q;
  logic [chgw_pkg::IdxW-1:0] cand_idx_q;
  logic [chgw_pkg::IdxW-1:0] start_idx_q;

  chgw_pkg::point_t start_pt_q;
  chgw_pkg::point_t cur_pt_q;
  chgw_pkg::point_t cand_pt_q;
  chgw_pkg::point_t b_pt_q;
  chgw_pkg::point_t out_pt_q;
  logic             out_last_q;
  logic             out_ovf_q;

  logic signed [chgw_pkg::ProdW-1:0] prod1_q;
  logic signed [chgw_pkg::ProdW-1:0] prod2_q;

  logic                      full;
  logic                      store_we;
  logic                      store_re;
  logic [chgw_pkg::IdxW-1:0] store_ra;
  logic [chgw_pkg::CntW-1:0] nxt_cnt;
  logic [chgw_pkg::IdxW-1:0] next_idx;
  logic                      take_min;
  logic [chgw_pkg::IdxW-1:0] start_idx_d;
  chgw_pkg::point_t          start_pt_d;

  logic signed [chgw_pkg::DiffW-1:0]  dy_ba;
  logic signed [chgw_pkg::DiffW-1:0]  dx_cb;
  logic signed [chgw_pkg::DiffW-1:0]  dx_ba;
  logic signed [chgw_pkg::DiffW-1:0]  dy_cb;
  logic signed [chgw_pkg::ProdW-1:0]  prod1_d;
  logic signed [chgw_pkg::ProdW-1:0]  prod2_d;
  logic signed [chgw_pkg::CrossW-1:0] cross_sum;
  logic                               ccw;

  assign full     = (count_q == chgw_pkg::CntW'(chgw_pkg::MaxPoints));
  assign store_we = cmd_i.load && !full;
  assign store_re = cmd_i.vtx || cmd_i.rd;
  assign nxt_cnt  = chgw_pkg::CntW'(cur_idx_q) + chgw_pkg::CntW'(1);
  assign next_idx = (nxt_cnt == count_q) ? '0 : nxt_cnt[chgw_pkg::IdxW-1:0];
  assign store_ra = cmd_i.vtx ? next_idx : i_q;

  // first point of least x
  assign take_min = (count_q == '0) || ($signed(pt_i.x) < $signed(start_pt_q.x));

  always_comb begin
    start_idx_d = start_idx_q;
    start_pt_d  = start_pt_q;
    if (store_we && take_min) begin
      start_idx_d = count_q[chgw_pkg::IdxW-1:0];
      start_pt_d  = pt_i;
    end
  end

  // a = current vertex, b = point under test, c = candidate
  assign dy_ba = $signed({store_rd_q.y[chgw_pkg::CoordBits-1], store_rd_q.y})
               - $signed({cur_pt_q.y[chgw_pkg::CoordBits-1], cur_pt_q.y});
  assign dx_cb = $signed({cand_pt_q.x[chgw_pkg::CoordBits-1], cand_pt_q.x})
               - $signed({store_rd_q.x[chgw_pkg::CoordBits-1], store_rd_q.x});
  assign dx_ba = $signed({store_rd_q.x[chgw_pkg::CoordBits-1], store_rd_q.x})
               - $signed({cur_pt_q.x[chgw_pkg::CoordBits-1], cur_pt_q.x});
  assign dy_cb = $signed({cand_pt_q.y[chgw_pkg::CoordBits-1], cand_pt_q.y})
               - $signed({store_rd_q.y[chgw_pkg::CoordBits-1], store_rd_q.y});

  assign prod1_d = $signed({{chgw_pkg::DiffW{dy_ba[chgw_pkg::DiffW-1]}}, dy_ba})
                 * $signed({{chgw_pkg::DiffW{dx_cb[chgw_pkg::DiffW-1]}}, dx_cb});
  assign prod2_d = $signed({{chgw_pkg::DiffW{dx_ba[chgw_pkg::DiffW-1]}}, dx_ba})
                 * $signed({{chgw_pkg::DiffW{dy_cb[chgw_pkg::DiffW-1]}}, dy_cb});

  assign cross_sum = $signed({prod1_q[chgw_pkg::ProdW-1], prod1_q})
                   - $signed({prod2_q[chgw_pkg::ProdW-1], prod2_q});
  assign ccw       = cross_sum[chgw_pkg::CrossW-1];

  assign stat_o.last_i   = ((chgw_pkg::CntW'(i_q) + chgw_pkg::CntW'(1)) == count_q);
  assign stat_o.at_start = (cand_idx_q == start_idx_q);
  assign stat_o.cap_hit  = (emit_q == chgw_pkg::CntW'(chgw_pkg::MaxPoints));
  assign stat_o.last_out = ((chgw_pkg::CntW'(k_q) + chgw_pkg::CntW'(1)) == emit_q);

  // memories
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[count_q[chgw_pkg::IdxW-1:0]] <= pt_i;
    end
    if (store_re) begin
      store_rd_q <= store_mem[store_ra];
    end
    if (cmd_i.vtx) begin
      walk_mem[emit_q[chgw_pkg::IdxW-1:0]] <= cur_pt_q;
    end
    if (cmd_i.out_rd) begin
      walk_rd_q <= walk_mem[k_q];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      emit_q      <= '0;
      dropped_q   <= 1'b0;
      capped_q    <= 1'b0;
      k_q         <= '0;
      i_q         <= '0;
      cur_idx_q   <= '0;
      cand_idx_q  <= '0;
      start_idx_q <= '0;
    end else begin
      if (cmd_i.load) begin
        start_idx_q <= start_idx_d;
        if (store_we) begin
          count_q <= count_q + chgw_pkg::CntW'(1);
        end else begin
          dropped_q <= 1'b1;
        end
        if (cmd_i.last_in) begin
          cur_idx_q <= start_idx_d;
        end
      end
      if (cmd_i.vtx) begin
        emit_q     <= emit_q + chgw_pkg::CntW'(1);
        cand_idx_q <= next_idx;
      end
      if (cmd_i.cand) begin
        i_q <= '0;
      end
      if (cmd_i.cmp) begin
        i_q <= i_q + chgw_pkg::IdxW'(1);
        if (ccw) begin
          cand_idx_q <= i_q;
        end
      end
      if (cmd_i.adv) begin
        cur_idx_q <= cand_idx_q;
        if (!stat_o.at_start && stat_o.cap_hit) begin
          capped_q <= 1'b1;
        end
      end
      if (cmd_i.out_done) begin
        if (stat_o.last_out) begin
          k_q       <= '0;
          count_q   <= '0;
          emit_q    <= '0;
          dropped_q <= 1'b0;
          capped_q  <= 1'b0;
        end else begin
          k_q <= k_q + chgw_pkg::IdxW'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      start_pt_q <= start_pt_d;
      if (cmd_i.last_in) begin
        cur_pt_q <= start_pt_d;
      end
    end
    if (cmd_i.cand) begin
      cand_pt_q <= store_rd_q;
    end
    if (cmd_i.mul) begin
      b_pt_q  <= store_rd_q;
      prod1_q <= prod1_d;
      prod2_q <= prod2_d;
    end
    if (cmd_i.cmp && ccw) begin
      cand_pt_q <= b_pt_q;
    end
    if (cmd_i.adv) begin
      cur_pt_q <= cand_pt_q;
    end
    if (cmd_i.out_cap) begin
      out_pt_q   <= walk_rd_q;
      out_last_q <= stat_o.last_out;
      out_ovf_q  <= dropped_q || capped_q;
    end
  end

  assign out_pt_o   = out_pt_q;
  assign out_last_o = out_last_q;
  assign out_ovf_o  = out_ovf_q;

endmodule

`default_nettype wire

// ----- rtl/chgw_ctrl.sv -----
// controller state machine: point loading, hull walk and vertex output sequencing
`default_nettype none

module chgw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  input  logic             out_ready_i,
  input  chgw_pkg::stat_t  stat_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output chgw_pkg::cmd_t   cmd_o
);

  chgw_pkg::state_e state_q;
  chgw_pkg::state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chgw_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      chgw_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.last_in = 1'b1;
            state_d       = chgw_pkg::ST_VTX;
          end
        end
      end
      chgw_pkg::ST_VTX: begin
        cmd_o.vtx = 1'b1;
        state_d   = chgw_pkg::ST_CAND;
      end
      chgw_pkg::ST_CAND: begin
        cmd_o.cand = 1'b1;
        state_d    = chgw_pkg::ST_RD;
      end
      chgw_pkg::ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = chgw_pkg::ST_MUL;
      end
      chgw_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = chgw_pkg::ST_CMP;
      end
      chgw_pkg::ST_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = stat_i.last_i ? chgw_pkg::ST_ADV : chgw_pkg::ST_RD;
      end
      chgw_pkg::ST_ADV: begin
        cmd_o.adv = 1'b1;
        if (stat_i.at_start || stat_i.cap_hit) begin
          state_d = chgw_pkg::ST_OUT_RD;
        end else begin
          state_d = chgw_pkg::ST_VTX;
        end
      end
      chgw_pkg::ST_OUT_RD: begin
        cmd_o.out_rd = 1'b1;
        state_d      = chgw_pkg::ST_OUT_CAP;
      end
      chgw_pkg::ST_OUT_CAP: begin
        cmd_o.out_cap = 1'b1;
        state_d       = chgw_pkg::ST_OUT_WAIT;
      end
      chgw_pkg::ST_OUT_WAIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.out_done = 1'b1;
          state_d = stat_i.last_out ? chgw_pkg::ST_LOAD : chgw_pkg::ST_OUT_RD;
        end
      end
      default: begin
        state_d = chgw_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/convex_hull_gift_wrap.sv -----
// top level of the gift wrap convex hull block
// points come in on the s_axis request channel, one per cycle while s_axis_tready is high
// a request with s_axis_tlast closes the set and starts the hull walk
// up to 64 points are kept, further points are dropped and flag overflow on the results
// while walking and sending, s_axis_tready stays low
// the walk starts at the first stored point of least x; for each hull vertex it makes one
// cross product test per stored point, each test being a store read, a multiply stage
// and a compare stage
// the first vertex is offered after an output read state and an output capture state
// after the walk the vertices go out on m_axis in order; each is read and captured in the
// output register, and the next is read only after the receiver takes it; m_axis_tlast marks
// the final vertex and m_axis_tuser carries overflow on every vertex of the run
// at most 64 vertices are sent per run; hitting that cap short of the start also flags overflow
// a stalled receiver simply holds the current vertex in the output register
// after the final vertex is taken the store empties and loading resumes
// reset empties the store and raises s_axis_tready; no clearing pass is needed
`default_nettype none

module convex_hull_gift_wrap (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [chgw_pkg::DataW-1:0] s_axis_tdata,   // point_x, point_y
  input  logic                       s_axis_tlast,   // last_point
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [chgw_pkg::DataW-1:0] m_axis_tdata,   // hull_x, hull_y
  output logic                       m_axis_tlast,   // last_vertex
  output logic                       m_axis_tuser    // overflow
);

  chgw_pkg::cmd_t   cmd;
  chgw_pkg::stat_t  stat;
  chgw_pkg::point_t in_pt;
  chgw_pkg::point_t out_pt;

  assign in_pt.x = s_axis_tdata[chgw_pkg::CoordBits-1:0];
  assign in_pt.y = s_axis_tdata[2*chgw_pkg::CoordBits-1:chgw_pkg::CoordBits];

  chgw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  chgw_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .pt_i       (in_pt),
    .stat_o     (stat),
    .out_pt_o   (out_pt),
    .out_last_o (m_axis_tlast),
    .out_ovf_o  (m_axis_tuser)
  );

  assign m_axis_tdata = chgw_pkg::DataW'(out_pt);

`include "convex_hull_gift_wrap_macros.svh"

  `CHGW_ASSERT_SAME(a_no_load_while_sending, m_axis_tvalid, !s_axis_tready,
    "point accepted while a hull vertex is pending")
  `CHGW_ASSERT_NEXT(a_walk_after_last, s_axis_tvalid && s_axis_tready && s_axis_tlast,
    !s_axis_tready && !m_axis_tvalid, "walk did not start after final point")
  `CHGW_ASSERT_NEXT(a_more_vertices, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
    !s_axis_tready, "loading resumed before the final vertex was sent")

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// testbench for the gift wrap convex hull block: point sets in, predicted hull vertices checked out
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned HoldCycles  = 600;
  localparam int unsigned RandomItems = 120;

  typedef struct packed {
    chgw_pkg::coord_t x;
    chgw_pkg::coord_t y;
    logic             is_final;
    logic             ovf;
  } hull_vertex_t;

  typedef enum int {
    SPREAD_FULL,
    SPREAD_GRID,
    SPREAD_EDGE
  } spread_e;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [chgw_pkg::DataW-1:0] s_axis_tdata  = '0;
  logic                       s_axis_tlast  = 1'b0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [chgw_pkg::DataW-1:0] m_axis_tdata;
  logic                       m_axis_tlast;
  logic                       m_axis_tuser;

  bit           idle_on       = 1'b1;
  int unsigned  hold_req_cnt  = 0;
  int unsigned  hold_ack_cnt  = 0;
  int unsigned  hold_left     = 0;
  int unsigned  mismatch_cnt  = 0;

  // hull predictor state
  chgw_pkg::coord_t store_x [chgw_pkg::MaxPoints];
  chgw_pkg::coord_t store_y [chgw_pkg::MaxPoints];
  int unsigned      stored_cnt     = 0;
  bit               points_dropped = 1'b0;
  hull_vertex_t     hull_queue [$];

  convex_hull_gift_wrap DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit turns_ccw(int unsigned a, int unsigned b, int unsigned c);
    longint ax, ay, bx, by, cx, cy, cross_sum;
    ax = $signed(store_x[a]);
    ay = $signed(store_y[a]);
    bx = $signed(store_x[b]);
    by = $signed(store_y[b]);
    cx = $signed(store_x[c]);
    cy = $signed(store_y[c]);
    cross_sum = (by - ay) * (cx - bx) - (bx - ax) * (cy - by);
    return cross_sum < 0;
  endfunction

  function automatic void take_point(chgw_pkg::coord_t px, chgw_pkg::coord_t py,
                                     logic is_final);
    int unsigned n, start, cur, cand;
    bit capped;
    int unsigned path [$];
    hull_vertex_t v;
    if (stored_cnt < chgw_pkg::MaxPoints) begin
      store_x[stored_cnt] = px;
      store_y[stored_cnt] = py;
      stored_cnt++;
    end else begin
      points_dropped = 1'b1;
    end
    if (!is_final) return;
    n = stored_cnt;
    start = 0;
    capped = 1'b0;
    for (int unsigned i = 1; i < n; i++) begin
      if ($signed(store_x[i]) < $signed(store_x[start])) start = i;
    end
    cur = start;
    do begin
      path.insert(path.size(), cur);
      cand = (cur + 1) % n;
      for (int unsigned i = 0; i < n; i++) begin
        if (turns_ccw(cur, i, cand)) cand = i;
      end
      cur = cand;
      if (cur != start && path.size() >= chgw_pkg::MaxPoints) capped = 1'b1;
    end while (cur != start && !capped);
    foreach (path[k]) begin
      v.x = store_x[path[k]];
      v.y = store_y[path[k]];
      v.is_final = (k == path.size() - 1);
      v.ovf = points_dropped || capped;
      hull_queue.insert(hull_queue.size(), v);
    end
    stored_cnt = 0;
    points_dropped = 1'b0;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic check_vertex();
    hull_vertex_t want;
    chgw_pkg::coord_t got_x, got_y;
    got_x = m_axis_tdata[chgw_pkg::CoordBits-1:0];
    got_y = m_axis_tdata[2*chgw_pkg::CoordBits-1:chgw_pkg::CoordBits];
    if (hull_queue.size() == 0) begin
      note_mismatch($sformatf("vertex (%0d,%0d) with nothing expected",
                              $signed(got_x), $signed(got_y)));
      return;
    end
    want = hull_queue.pop_front();
    if (got_x !== want.x)
      note_mismatch($sformatf("hull_x %0d, want %0d", $signed(got_x), $signed(want.x)));
    if (got_y !== want.y)
      note_mismatch($sformatf("hull_y %0d, want %0d", $signed(got_y), $signed(want.y)));
    if (m_axis_tlast !== want.is_final)
      note_mismatch($sformatf("last_vertex %b, want %b", m_axis_tlast, want.is_final));
    if (m_axis_tuser !== want.ovf)
      note_mismatch($sformatf("overflow %b, want %b", m_axis_tuser, want.ovf));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        take_point(s_axis_tdata[chgw_pkg::CoordBits-1:0],
                   s_axis_tdata[2*chgw_pkg::CoordBits-1:chgw_pkg::CoordBits],
                   s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_vertex();
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req_cnt != hold_ack_cnt) begin
      hold_ack_cnt  <= hold_req_cnt;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 13);
    end
  end

  task automatic send_point(input int px, input int py, input logic is_final);
    while (idle_on && $urandom_range(0, 99) < 13) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {chgw_pkg::coord_t'(py), chgw_pkg::coord_t'(px)};
    s_axis_tlast  <= is_final;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic int pick_coord(spread_e spread);
    int r;
    case (spread)
      SPREAD_GRID: begin
        r = int'($urandom_range(0, 6)) - 3;
      end
      SPREAD_EDGE: begin
        case ($urandom_range(0, 4))
          0: r = -32768;
          1: r = 32767;
          2: r = 0;
          3: r = -1;
          default: r = int'($urandom_range(0, 65535)) - 32768;
        endcase
      end
      default: begin
        r = int'($urandom_range(0, 65535)) - 32768;
      end
    endcase
    return r;
  endfunction

  task automatic wait_hull_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (hull_queue.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_small_sets();
    send_point(123, -456, 1'b1);
    send_point(5, 5, 1'b0);
    send_point(-5, -5, 1'b1);
    // points on one line
    send_point(0, 0, 1'b0);
    send_point(3, 3, 1'b0);
    send_point(-2, -2, 1'b1);
    // all points the same
    send_point(7, -7, 1'b0);
    send_point(7, -7, 1'b0);
    send_point(7, -7, 1'b1);
  endtask

  task automatic test_extremes();
    send_point(0, 0, 1'b0);
    send_point(32767, -32768, 1'b0);
    send_point(32767, 32767, 1'b0);
    send_point(-32768, 32767, 1'b0);
    send_point(-32768, -32768, 1'b1);
  endtask

  // duplicate of the start point sends the walk into a loop that misses the start
  task automatic test_wrap_cap();
    send_point(0, 0, 1'b0);
    send_point(10, 0, 1'b0);
    send_point(0, 10, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(10, 0, 1'b1);
  endtask

  // the final point lands past capacity and is dropped, yet still starts the walk
  task automatic test_store_full();
    for (int k = 0; k < chgw_pkg::MaxPoints + 2; k++)
      send_point(pick_coord(SPREAD_FULL), pick_coord(SPREAD_FULL),
                 k == chgw_pkg::MaxPoints + 1);
  endtask

  task automatic test_receiver_hold();
    wait_hull_drain();
    hold_req_cnt <= hold_req_cnt + 1;
    for (int k = 0; k < 8; k++)
      send_point(pick_coord(SPREAD_FULL), pick_coord(SPREAD_FULL), k == 7);
    for (int k = 0; k < 6; k++)
      send_point(pick_coord(SPREAD_EDGE), pick_coord(SPREAD_FULL), k == 5);
  endtask

  task automatic test_random_sets();
    int sent, set_no, set_size, roll;
    spread_e spread;
    sent = 0;
    set_no = 0;
    while (sent < RandomItems) begin
      idle_on <= !(set_no >= 8 && set_no < 16);
      roll = $urandom_range(0, 99);
      if (roll < 5) set_size = $urandom_range(40, chgw_pkg::MaxPoints + 3);
      else if (roll < 15) set_size = $urandom_range(1, 2);
      else set_size = $urandom_range(3, 12);
      spread = spread_e'($urandom_range(0, 2));
      for (int k = 0; k < set_size; k++)
        send_point(pick_coord(spread), pick_coord(spread), k == set_size - 1);
      sent += set_size;
      set_no++;
    end
    idle_on <= 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_small_sets();
    test_extremes();
    test_wrap_cap();
    test_store_full();
    test_receiver_hold();
    test_random_sets();
    s_axis_tvalid <= 1'b0;
    wait_hull_drain();
    repeat (50) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
